### rtl/c6502_pkg.sv
`timescale 1ns / 1ps

package c6502_pkg;

   // Status bit positions, N V 1 B D I Z C from bit 7 down to bit 0
   localparam int FLAG_N = 7;
   localparam int FLAG_V = 6;
   localparam int FLAG_R = 5;
   localparam int FLAG_B = 4;
   localparam int FLAG_D = 3;
   localparam int FLAG_I = 2;
   localparam int FLAG_Z = 1;
   localparam int FLAG_C = 0;

   localparam logic [7:0] SP_RESET     = 8'hFD;
   localparam logic [7:0] STATUS_RESET = 8'h24;
   localparam logic [7:0] MASK_BR      = 8'h30;  // B and bit 5, as pushed by PHP
   localparam logic [7:0] MASK_B       = 8'h10;
   localparam logic [7:0] MASK_R       = 8'h20;

   typedef enum logic [5:0] {
      K_ORA, K_AND, K_EOR, K_ADC, K_SBC, K_CMP, K_CPX, K_CPY,
      K_LDA, K_LDX, K_LDY, K_STA, K_STX, K_STY,
      K_ASL_A, K_ROL_A, K_LSR_A, K_ROR_A,
      K_ASL_M, K_ROL_M, K_LSR_M, K_ROR_M, K_DEC_M, K_INC_M,
      K_BIT, K_BRANCH,
      K_CLC, K_SEC, K_CLI, K_SEI, K_CLV, K_CLD, K_SED,
      K_TAX, K_TAY, K_TSX, K_TXA, K_TYA, K_TXS,
      K_INX, K_INY, K_DEX, K_DEY,
      K_PHA, K_PHP, K_PLA, K_PLP, K_NOP,
      K_LAX, K_SAX, K_DCP, K_ISB, K_SLO, K_RLA, K_SRE, K_RRA,
      K_ANC, K_ALR, K_ARR, K_AXS, K_SYA, K_SXA,
      K_INVALID
   } op_kind_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] p;
   } regs_type;

   typedef struct packed {
      logic [7:0] write_data;
      logic       write_enable;
      logic       branch_taken;
      logic       invalid_op;
   } side_type;

   // Update N and Z from a result byte
   function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] r;
      r         = p;
      r[FLAG_Z] = (v == 8'h00);
      r[FLAG_N] = v[7];
      return r;
   endfunction

endpackage

### rtl/c6502_decode.sv
`timescale 1ns / 1ps

module c6502_decode (
   input  logic [7:0]                op,
   output c6502_pkg::op_kind_type    kind
);

   always_comb begin
      case (op) inside
         8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: kind = c6502_pkg::K_ORA;
         8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: kind = c6502_pkg::K_AND;
         8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: kind = c6502_pkg::K_EOR;
         8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: kind = c6502_pkg::K_ADC;
         8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD, 8'hEB:
            kind = c6502_pkg::K_SBC;
         8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: kind = c6502_pkg::K_CMP;
         8'hE0, 8'hE4, 8'hEC: kind = c6502_pkg::K_CPX;
         8'hC0, 8'hC4, 8'hCC: kind = c6502_pkg::K_CPY;
         8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: kind = c6502_pkg::K_LDA;
         8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: kind = c6502_pkg::K_LDX;
         8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: kind = c6502_pkg::K_LDY;
         8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D: kind = c6502_pkg::K_STA;
         8'h86, 8'h8E, 8'h96: kind = c6502_pkg::K_STX;
         8'h84, 8'h8C, 8'h94: kind = c6502_pkg::K_STY;
         8'h0A: kind = c6502_pkg::K_ASL_A;
         8'h2A: kind = c6502_pkg::K_ROL_A;
         8'h4A: kind = c6502_pkg::K_LSR_A;
         8'h6A: kind = c6502_pkg::K_ROR_A;
         8'h06, 8'h0E, 8'h16, 8'h1E: kind = c6502_pkg::K_ASL_M;
         8'h26, 8'h2E, 8'h36, 8'h3E: kind = c6502_pkg::K_ROL_M;
         8'h46, 8'h4E, 8'h56, 8'h5E: kind = c6502_pkg::K_LSR_M;
         8'h66, 8'h6E, 8'h76, 8'h7E: kind = c6502_pkg::K_ROR_M;
         8'hC6, 8'hCE, 8'hD6, 8'hDE: kind = c6502_pkg::K_DEC_M;
         8'hE6, 8'hEE, 8'hF6, 8'hFE: kind = c6502_pkg::K_INC_M;
         8'h24, 8'h2C: kind = c6502_pkg::K_BIT;
         8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0:
            kind = c6502_pkg::K_BRANCH;
         8'h18: kind = c6502_pkg::K_CLC;
         8'h38: kind = c6502_pkg::K_SEC;
         8'h58: kind = c6502_pkg::K_CLI;
         8'h78: kind = c6502_pkg::K_SEI;
         8'hB8: kind = c6502_pkg::K_CLV;
         8'hD8: kind = c6502_pkg::K_CLD;
         8'hF8: kind = c6502_pkg::K_SED;
         8'hAA: kind = c6502_pkg::K_TAX;
         8'hA8: kind = c6502_pkg::K_TAY;
         8'hBA: kind = c6502_pkg::K_TSX;
         8'h8A: kind = c6502_pkg::K_TXA;
         8'h98: kind = c6502_pkg::K_TYA;
         8'h9A: kind = c6502_pkg::K_TXS;
         8'hE8: kind = c6502_pkg::K_INX;
         8'hC8: kind = c6502_pkg::K_INY;
         8'hCA: kind = c6502_pkg::K_DEX;
         8'h88: kind = c6502_pkg::K_DEY;
         8'h48: kind = c6502_pkg::K_PHA;
         8'h08: kind = c6502_pkg::K_PHP;
         8'h68: kind = c6502_pkg::K_PLA;
         8'h28: kind = c6502_pkg::K_PLP;
         // control flow and the documented/undocumented no-ops
         8'h00, 8'h20, 8'h40, 8'h60, 8'h4C, 8'h6C,
         8'hEA, 8'h04, 8'h44, 8'h64, 8'h0C, 8'h14, 8'h34, 8'h54,
         8'h74, 8'hD4, 8'hF4, 8'h1A, 8'h3A, 8'h5A, 8'h7A, 8'hDA,
         8'hFA, 8'h80, 8'h82, 8'h89, 8'hC2, 8'hE2, 8'h1C, 8'h3C,
         8'h5C, 8'h7C, 8'hDC, 8'hFC: kind = c6502_pkg::K_NOP;
         8'hA3, 8'hA7, 8'hAF, 8'hB3, 8'hB7, 8'hBF, 8'hAB: kind = c6502_pkg::K_LAX;
         8'h83, 8'h87, 8'h8F, 8'h97: kind = c6502_pkg::K_SAX;
         8'hC3, 8'hC7, 8'hCF, 8'hD3, 8'hD7, 8'hDB, 8'hDF: kind = c6502_pkg::K_DCP;
         8'hE3, 8'hE7, 8'hEF, 8'hF3, 8'hF7, 8'hFB, 8'hFF: kind = c6502_pkg::K_ISB;
         8'h03, 8'h07, 8'h0F, 8'h13, 8'h17, 8'h1B, 8'h1F: kind = c6502_pkg::K_SLO;
         8'h23, 8'h27, 8'h2F, 8'h33, 8'h37, 8'h3B, 8'h3F: kind = c6502_pkg::K_RLA;
         8'h43, 8'h47, 8'h4F, 8'h53, 8'h57, 8'h5B, 8'h5F: kind = c6502_pkg::K_SRE;
         8'h63, 8'h67, 8'h6F, 8'h73, 8'h77, 8'h7B, 8'h7F: kind = c6502_pkg::K_RRA;
         8'h0B, 8'h2B: kind = c6502_pkg::K_ANC;
         8'h4B: kind = c6502_pkg::K_ALR;
         8'h6B: kind = c6502_pkg::K_ARR;
         8'hCB: kind = c6502_pkg::K_AXS;
         8'h9C: kind = c6502_pkg::K_SYA;
         8'h9E: kind = c6502_pkg::K_SXA;
         default: kind = c6502_pkg::K_INVALID;
      endcase
   end

endmodule

### rtl/c6502_exec.sv
`timescale 1ns / 1ps

module c6502_exec (
   input  c6502_pkg::op_kind_type kind,
   input  logic [7:0]             op,
   input  logic [7:0]             operand,
   input  logic [7:0]             addr_high,
   input  c6502_pkg::regs_type    cur,
   output c6502_pkg::regs_type    nxt,
   output c6502_pkg::side_type    side
);

   logic       acc_shift;
   logic [7:0] shift_src;
   logic [7:0] asl_res;
   logic [7:0] rol_res;
   logic [7:0] lsr_res;
   logic [7:0] ror_res;
   logic [7:0] inc_m;
   logic [7:0] dec_m;
   logic [7:0] and_m;
   logic [7:0] and_ax;
   logic [7:0] arr_t;
   logic [7:0] add_b;
   logic       add_cin;
   logic [8:0] add_sum;
   logic       add_v;
   logic [7:0] cmp_r;
   logic [7:0] cmp_v;
   logic [8:0] cmp_diff;
   logic       cmp_c;
   logic       cond_flag;
   logic [7:0] p_add;
   logic [7:0] p_cmp;

   assign acc_shift = (kind == c6502_pkg::K_ASL_A) || (kind == c6502_pkg::K_ROL_A) ||
                      (kind == c6502_pkg::K_LSR_A) || (kind == c6502_pkg::K_ROR_A);
   assign shift_src = acc_shift ? cur.acc : operand;
   assign asl_res   = {shift_src[6:0], 1'b0};
   assign rol_res   = {shift_src[6:0], cur.p[c6502_pkg::FLAG_C]};
   assign lsr_res   = {1'b0, shift_src[7:1]};
   assign ror_res   = {cur.p[c6502_pkg::FLAG_C], shift_src[7:1]};
   assign inc_m     = operand + 8'd1;
   assign dec_m     = operand - 8'd1;
   assign and_m     = cur.acc & operand;
   assign and_ax    = cur.acc & cur.x;
   assign arr_t     = {cur.p[c6502_pkg::FLAG_C], and_m[7:1]};

   // Shared adder: ADC, SBC, ISB and RRA
   always_comb begin
      case (kind)
         c6502_pkg::K_SBC: add_b = ~operand;
         c6502_pkg::K_ISB: add_b = ~inc_m;
         c6502_pkg::K_RRA: add_b = ror_res;
         default:          add_b = operand;
      endcase
   end

   // RRA adds with the carry its rotate just produced
   assign add_cin = (kind == c6502_pkg::K_RRA) ? operand[0] : cur.p[c6502_pkg::FLAG_C];
   assign add_sum = {1'b0, cur.acc} + {1'b0, add_b} + {8'd0, add_cin};
   assign add_v   = (cur.acc[7] ~^ add_b[7]) & (cur.acc[7] ^ add_sum[7]);

   always_comb begin
      p_add                      = c6502_pkg::set_nz(cur.p, add_sum[7:0]);
      p_add[c6502_pkg::FLAG_C]   = add_sum[8];
      p_add[c6502_pkg::FLAG_V]   = add_v;
   end

   // Shared comparator: CMP, CPX, CPY, DCP and AXS
   always_comb begin
      case (kind)
         c6502_pkg::K_CPX: cmp_r = cur.x;
         c6502_pkg::K_CPY: cmp_r = cur.y;
         c6502_pkg::K_AXS: cmp_r = and_ax;
         default:          cmp_r = cur.acc;
      endcase
   end

   assign cmp_v    = (kind == c6502_pkg::K_DCP) ? dec_m : operand;
   assign cmp_diff = {1'b0, cmp_r} - {1'b0, cmp_v};
   assign cmp_c    = ~cmp_diff[8];

   always_comb begin
      p_cmp                    = c6502_pkg::set_nz(cur.p, cmp_diff[7:0]);
      p_cmp[c6502_pkg::FLAG_C] = cmp_c;
   end

   // Branch flag picked by opcode bits 7:6, compared against bit 5
   always_comb begin
      case (op[7:6])
         2'b00:   cond_flag = cur.p[c6502_pkg::FLAG_N];
         2'b01:   cond_flag = cur.p[c6502_pkg::FLAG_V];
         2'b10:   cond_flag = cur.p[c6502_pkg::FLAG_C];
         default: cond_flag = cur.p[c6502_pkg::FLAG_Z];
      endcase
   end

   always_comb begin
      nxt               = cur;
      side.write_data   = 8'h00;
      side.write_enable = 1'b0;
      side.branch_taken = 1'b0;
      side.invalid_op   = 1'b0;
      case (kind)
         c6502_pkg::K_ORA: begin
            nxt.acc = cur.acc | operand;
            nxt.p   = c6502_pkg::set_nz(cur.p, cur.acc | operand);
         end
         c6502_pkg::K_AND: begin
            nxt.acc = and_m;
            nxt.p   = c6502_pkg::set_nz(cur.p, and_m);
         end
         c6502_pkg::K_EOR: begin
            nxt.acc = cur.acc ^ operand;
            nxt.p   = c6502_pkg::set_nz(cur.p, cur.acc ^ operand);
         end
         c6502_pkg::K_ADC, c6502_pkg::K_SBC: begin
            nxt.acc = add_sum[7:0];
            nxt.p   = p_add;
         end
         c6502_pkg::K_CMP, c6502_pkg::K_CPX, c6502_pkg::K_CPY: nxt.p = p_cmp;
         c6502_pkg::K_LDA: begin
            nxt.acc = operand;
            nxt.p   = c6502_pkg::set_nz(cur.p, operand);
         end
         c6502_pkg::K_LDX: begin
            nxt.x = operand;
            nxt.p = c6502_pkg::set_nz(cur.p, operand);
         end
         c6502_pkg::K_LDY: begin
            nxt.y = operand;
            nxt.p = c6502_pkg::set_nz(cur.p, operand);
         end
         c6502_pkg::K_STA: begin
            side.write_data   = cur.acc;
            side.write_enable = 1'b1;
         end
         c6502_pkg::K_STX: begin
            side.write_data   = cur.x;
            side.write_enable = 1'b1;
         end
         c6502_pkg::K_STY: begin
            side.write_data   = cur.y;
            side.write_enable = 1'b1;
         end
         c6502_pkg::K_ASL_A: begin
            nxt.acc                  = asl_res;
            nxt.p                    = c6502_pkg::set_nz(cur.p, asl_res);
            nxt.p[c6502_pkg::FLAG_C] = shift_src[7];
         end
         c6502_pkg::K_ROL_A: begin
            nxt.acc                  = rol_res;
            nxt.p                    = c6502_pkg::set_nz(cur.p, rol_res);
            nxt.p[c6502_pkg::FLAG_C] = shift_src[7];
         end
         c6502_pkg::K_LSR_A: begin
            nxt.acc                  = lsr_res;
            nxt.p                    = c6502_pkg::set_nz(cur.p, lsr_res);
            nxt.p[c6502_pkg::FLAG_C] = shift_src[0];
         end
         c6502_pkg::K_ROR_A: begin
            nxt.acc                  = ror_res;
            nxt.p                    = c6502_pkg::set_nz(cur.p, ror_res);
            nxt.p[c6502_pkg::FLAG_C] = shift_src[0];
         end
         c6502_pkg::K_ASL_M: begin
            side.write_data          = asl_res;
            side.write_enable        = 1'b1;
            nxt.p                    = c6502_pkg::set_nz(cur.p, asl_res);
            nxt.p[c6502_pkg::FLAG_C] = shift_src[7];
         end
         c6502_pkg::K_ROL_M: begin
            side.write_data          = rol_res;
            side.write_enable        = 1'b1;
            nxt.p                    = c6502_pkg::set_nz(cur.p, rol_res);
            nxt.p[c6502_pkg::FLAG_C] = shift_src[7];
         end
         c6502_pkg::K_LSR_M: begin
            side.write_data          = lsr_res;
            side.write_enable        = 1'b1;
            nxt.p                    = c6502_pkg::set_nz(cur.p, lsr_res);
            nxt.p[c6502_pkg::FLAG_C] = shift_src[0];
         end
         c6502_pkg::K_ROR_M: begin
            side.write_data          = ror_res;
            side.write_enable        = 1'b1;
            nxt.p                    = c6502_pkg::set_nz(cur.p, ror_res);
            nxt.p[c6502_pkg::FLAG_C] = shift_src[0];
         end
         c6502_pkg::K_DEC_M: begin
            side.write_data   = dec_m;
            side.write_enable = 1'b1;
            nxt.p             = c6502_pkg::set_nz(cur.p, dec_m);
         end
         c6502_pkg::K_INC_M: begin
            side.write_data   = inc_m;
            side.write_enable = 1'b1;
            nxt.p             = c6502_pkg::set_nz(cur.p, inc_m);
         end
         c6502_pkg::K_BIT: begin
            nxt.p[c6502_pkg::FLAG_Z] = (and_m == 8'h00);
            nxt.p[c6502_pkg::FLAG_V] = operand[6];
            nxt.p[c6502_pkg::FLAG_N] = operand[7];
         end
         c6502_pkg::K_BRANCH: side.branch_taken = (cond_flag == op[5]);
         c6502_pkg::K_CLC: nxt.p[c6502_pkg::FLAG_C] = 1'b0;
         c6502_pkg::K_SEC: nxt.p[c6502_pkg::FLAG_C] = 1'b1;
         c6502_pkg::K_CLI: nxt.p[c6502_pkg::FLAG_I] = 1'b0;
         c6502_pkg::K_SEI: nxt.p[c6502_pkg::FLAG_I] = 1'b1;
         c6502_pkg::K_CLV: nxt.p[c6502_pkg::FLAG_V] = 1'b0;
         c6502_pkg::K_CLD: nxt.p[c6502_pkg::FLAG_D] = 1'b0;
         c6502_pkg::K_SED: nxt.p[c6502_pkg::FLAG_D] = 1'b1;
         c6502_pkg::K_TAX: begin
            nxt.x = cur.acc;
            nxt.p = c6502_pkg::set_nz(cur.p, cur.acc);
         end
         c6502_pkg::K_TAY: begin
            nxt.y = cur.acc;
            nxt.p = c6502_pkg::set_nz(cur.p, cur.acc);
         end
         c6502_pkg::K_TSX: begin
            nxt.x = cur.sp;
            nxt.p = c6502_pkg::set_nz(cur.p, cur.sp);
         end
         c6502_pkg::K_TXA: begin
            nxt.acc = cur.x;
            nxt.p   = c6502_pkg::set_nz(cur.p, cur.x);
         end
         c6502_pkg::K_TYA: begin
            nxt.acc = cur.y;
            nxt.p   = c6502_pkg::set_nz(cur.p, cur.y);
         end
         c6502_pkg::K_TXS: nxt.sp = cur.x;
         c6502_pkg::K_INX: begin
            nxt.x = cur.x + 8'd1;
            nxt.p = c6502_pkg::set_nz(cur.p, cur.x + 8'd1);
         end
         c6502_pkg::K_INY: begin
            nxt.y = cur.y + 8'd1;
            nxt.p = c6502_pkg::set_nz(cur.p, cur.y + 8'd1);
         end
         c6502_pkg::K_DEX: begin
            nxt.x = cur.x - 8'd1;
            nxt.p = c6502_pkg::set_nz(cur.p, cur.x - 8'd1);
         end
         c6502_pkg::K_DEY: begin
            nxt.y = cur.y - 8'd1;
            nxt.p = c6502_pkg::set_nz(cur.p, cur.y - 8'd1);
         end
         c6502_pkg::K_PHA: begin
            side.write_data   = cur.acc;
            side.write_enable = 1'b1;
            nxt.sp            = cur.sp - 8'd1;
         end
         c6502_pkg::K_PHP: begin
            side.write_data   = cur.p | c6502_pkg::MASK_BR;
            side.write_enable = 1'b1;
            nxt.sp            = cur.sp - 8'd1;
         end
         c6502_pkg::K_PLA: begin
            nxt.sp  = cur.sp + 8'd1;
            nxt.acc = operand;
            nxt.p   = c6502_pkg::set_nz(cur.p, operand);
         end
         c6502_pkg::K_PLP: begin
            nxt.sp = cur.sp + 8'd1;
            nxt.p  = (operand & ~c6502_pkg::MASK_B) | c6502_pkg::MASK_R;
         end
         c6502_pkg::K_NOP: nxt = cur;
         c6502_pkg::K_LAX: begin
            nxt.acc = operand;
            nxt.x   = operand;
            nxt.p   = c6502_pkg::set_nz(cur.p, operand);
         end
         c6502_pkg::K_SAX: begin
            side.write_data   = and_ax;
            side.write_enable = 1'b1;
         end
         c6502_pkg::K_DCP: begin
            side.write_data   = dec_m;
            side.write_enable = 1'b1;
            nxt.p             = p_cmp;
         end
         c6502_pkg::K_ISB: begin
            side.write_data   = inc_m;
            side.write_enable = 1'b1;
            nxt.acc           = add_sum[7:0];
            nxt.p             = p_add;
         end
         c6502_pkg::K_SLO: begin
            side.write_data          = asl_res;
            side.write_enable        = 1'b1;
            nxt.acc                  = cur.acc | asl_res;
            nxt.p                    = c6502_pkg::set_nz(cur.p, cur.acc | asl_res);
            nxt.p[c6502_pkg::FLAG_C] = operand[7];
         end
         c6502_pkg::K_RLA: begin
            side.write_data          = rol_res;
            side.write_enable        = 1'b1;
            nxt.acc                  = cur.acc & rol_res;
            nxt.p                    = c6502_pkg::set_nz(cur.p, cur.acc & rol_res);
            nxt.p[c6502_pkg::FLAG_C] = operand[7];
         end
         c6502_pkg::K_SRE: begin
            side.write_data          = lsr_res;
            side.write_enable        = 1'b1;
            nxt.acc                  = cur.acc ^ lsr_res;
            nxt.p                    = c6502_pkg::set_nz(cur.p, cur.acc ^ lsr_res);
            nxt.p[c6502_pkg::FLAG_C] = operand[0];
         end
         c6502_pkg::K_RRA: begin
            side.write_data   = ror_res;
            side.write_enable = 1'b1;
            nxt.acc           = add_sum[7:0];
            nxt.p             = p_add;
         end
         c6502_pkg::K_ANC: begin
            nxt.acc                  = and_m;
            nxt.p                    = c6502_pkg::set_nz(cur.p, and_m);
            nxt.p[c6502_pkg::FLAG_C] = and_m[7];
         end
         c6502_pkg::K_ALR: begin
            nxt.acc                  = {1'b0, and_m[7:1]};
            nxt.p                    = c6502_pkg::set_nz(cur.p, {1'b0, and_m[7:1]});
            nxt.p[c6502_pkg::FLAG_C] = and_m[0];
         end
         c6502_pkg::K_ARR: begin
            nxt.acc                  = arr_t;
            nxt.p                    = c6502_pkg::set_nz(cur.p, arr_t);
            nxt.p[c6502_pkg::FLAG_C] = arr_t[6];
            nxt.p[c6502_pkg::FLAG_V] = arr_t[6] ^ arr_t[5];
         end
         c6502_pkg::K_AXS: begin
            nxt.x = cmp_diff[7:0];
            nxt.p = p_cmp;
         end
         c6502_pkg::K_SYA: begin
            side.write_data   = cur.y & (addr_high + 8'd1);
            side.write_enable = 1'b1;
         end
         c6502_pkg::K_SXA: begin
            side.write_data   = cur.x & (addr_high + 8'd1);
            side.write_enable = 1'b1;
         end
         default: side.invalid_op = 1'b1;
      endcase
   end

endmodule

### rtl/cpu6502_alu_register_step.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Word
// req      in         req_valid / req_ready  op, operand, addr_high
// rsp      out        rsp_valid / rsp_ready  acc, index_x, index_y, stack_ptr, status,
//                                            write_data, write_enable, branch_taken,
//                                            invalid_op
//
// One instruction per cycle while rsp is not stalled. A word sits in the input register with
// its decoded operation class; the execute logic then writes A, X, Y, S and P and the
// result register in the same edge, so the next word always sees the updated registers.
// An accepted word passes through the input register and then the result register to rsp_valid.
// Synchronous reset clears both valid flags and loads A = X = Y = 0, S = 0xFD, P = 0x24.
// A stalled rsp holds its word; the input register still takes a word and holds it
// until the result register frees, so req_ready drops only when both stages are full.

module cpu6502_alu_register_step (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_op,
   input  logic [7:0] req_operand,
   input  logic [7:0] req_addr_high,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_acc,
   output logic [7:0] rsp_index_x,
   output logic [7:0] rsp_index_y,
   output logic [7:0] rsp_stack_ptr,
   output logic [7:0] rsp_status,
   output logic [7:0] rsp_write_data,
   output logic       rsp_write_enable,
   output logic       rsp_branch_taken,
   output logic       rsp_invalid_op
);

   // Input register
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   c6502_pkg::op_kind_type s1_kind_ff;
   c6502_pkg::op_kind_type req_kind;
   logic [7:0]             s1_op_ff;
   logic [7:0]             s1_operand_ff;
   logic [7:0]             s1_addr_high_ff;

   // Architectural registers
   c6502_pkg::regs_type    regs_ff;
   c6502_pkg::regs_type    regs_in;
   c6502_pkg::side_type    side_in;

   // Result register
   logic                   out_valid_ff;
   logic                   out_valid_in;
   c6502_pkg::regs_type    out_regs_ff;
   c6502_pkg::side_type    out_side_ff;

   logic                   req_take;
   logic                   s1_advance;

   // Decode ahead of the input register, so the execute stage starts from the class
   c6502_decode u_decode (
      .op   (req_op),
      .kind (req_kind)
   );

   c6502_exec u_exec (
      .kind      (s1_kind_ff),
      .op        (s1_op_ff),
      .operand   (s1_operand_ff),
      .addr_high (s1_addr_high_ff),
      .cur       (regs_ff),
      .nxt       (regs_in),
      .side      (side_in)
   );

   // Advance the input stage when the result register is empty or being drained
   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         regs_ff.acc  <= 8'h00;
         regs_ff.x    <= 8'h00;
         regs_ff.y    <= 8'h00;
         regs_ff.sp   <= c6502_pkg::SP_RESET;
         regs_ff.p    <= c6502_pkg::STATUS_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         // commit the architectural state only when the word moves to the result register
         if (s1_advance) begin
            regs_ff <= regs_in;
         end
      end
   end

   // Payload registers: load on the handshake, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff      <= req_kind;
         s1_op_ff        <= req_op;
         s1_operand_ff   <= req_operand;
         s1_addr_high_ff <= req_addr_high;
      end
      if (s1_advance) begin
         out_regs_ff <= regs_in;
         out_side_ff <= side_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_acc          = out_regs_ff.acc;
   assign rsp_index_x      = out_regs_ff.x;
   assign rsp_index_y      = out_regs_ff.y;
   assign rsp_stack_ptr    = out_regs_ff.sp;
   assign rsp_status       = out_regs_ff.p;
   assign rsp_write_data   = out_side_ff.write_data;
   assign rsp_write_enable = out_side_ff.write_enable;
   assign rsp_branch_taken = out_side_ff.branch_taken;
   assign rsp_invalid_op   = out_side_ff.invalid_op;

   // The result word always mirrors the registers committed with it
   a_commit_match : assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> (out_regs_ff == regs_ff))
      else $error("result word differs from committed registers");

   // Bit 5 of the status register can never be cleared
   a_status_bit5 : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status[c6502_pkg::FLAG_R])
      else $error("status bit 5 clear");

   // No write data leaks out without a write strobe
   a_quiet_write : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_enable) |-> (rsp_write_data == 8'h00))
      else $error("write data without strobe");

   // An undecoded opcode neither writes nor branches
   a_invalid_quiet : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid_op) |-> (!rsp_write_enable && !rsp_branch_taken))
      else $error("undecoded opcode with side effects");

endmodule

### tb/cpu6502_alu_register_step_tb.sv
`timescale 1ns / 1ps

module cpu6502_alu_register_step_tb;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 7;
   localparam int WATCHDOG_NS  = 2_000_000;
   localparam int HOLD_CYCLES  = 60;   // long rsp back-pressure, fills both stages
   localparam int HOLD_AFTER   = 80;   // words retired before the long hold starts
   localparam int RANDOM_WORDS = 120;
   localparam int CALM_FROM    = 80;   // random words after this run with no idling
   localparam int SETTLE       = 8;

   // Opcodes used by name outside the decode table
   localparam logic [7:0] OP_JAM     = 8'h02;  // undecoded
   localparam logic [7:0] OP_XAA     = 8'h8B;  // undecoded here
   localparam logic [7:0] OP_LDA_IMM = 8'hA9;
   localparam logic [7:0] OP_LDX_IMM = 8'hA2;
   localparam logic [7:0] OP_ADC_IMM = 8'h69;
   localparam logic [7:0] OP_SBC_IMM = 8'hE9;
   localparam logic [7:0] OP_PHP     = 8'h08;
   localparam logic [7:0] OP_PLP     = 8'h28;
   localparam logic [7:0] OP_PHA     = 8'h48;
   localparam logic [7:0] OP_PLA     = 8'h68;
   localparam logic [7:0] OP_TXS     = 8'h9A;
   localparam logic [7:0] OP_TSX     = 8'hBA;
   localparam logic [7:0] OP_BPL     = 8'h10;
   localparam logic [7:0] OP_BMI     = 8'h30;
   localparam logic [7:0] OP_BVC     = 8'h50;
   localparam logic [7:0] OP_BVS     = 8'h70;
   localparam logic [7:0] OP_BCC     = 8'h90;
   localparam logic [7:0] OP_BCS     = 8'hB0;
   localparam logic [7:0] OP_BEQ     = 8'hF0;
   localparam logic [7:0] OP_ARR     = 8'h6B;
   localparam logic [7:0] OP_AXS     = 8'hCB;
   localparam logic [7:0] OP_SXA     = 8'h9E;
   localparam logic [7:0] OP_ATX     = 8'hAB;
   localparam logic [7:0] OP_RRA_ABX = 8'h7F;
   localparam logic [7:0] OP_ISB_IZX = 8'hE3;
   localparam logic [7:0] OP_DCP_IZX = 8'hC3;
   localparam logic [7:0] OP_BIT_ZP  = 8'h24;
   localparam logic [7:0] OP_SED     = 8'hF8;

   // One retired instruction as it leaves on the rsp channel
   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] p;
      logic [7:0] wd;
      logic       we;
      logic       br;
      logic       bad;
   } retire_type;

   localparam retire_type NO_WANT = '0;

   // Directed row: the req word, and a hand-written result where one is given
   typedef struct packed {
      logic [7:0] op;
      logic [7:0] operand;
      logic [7:0] hi;
      logic       typed;
      retire_type want;
   } stim_row_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [7:0] req_op        = 8'h00;
   logic [7:0] req_operand   = 8'h00;
   logic [7:0] req_addr_high = 8'h00;
   logic       rsp_ready     = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_acc;
   logic [7:0] rsp_index_x;
   logic [7:0] rsp_index_y;
   logic [7:0] rsp_stack_ptr;
   logic [7:0] rsp_status;
   logic [7:0] rsp_write_data;
   logic       rsp_write_enable;
   logic       rsp_branch_taken;
   logic       rsp_invalid_op;

   cpu6502_alu_register_step dut (.*);

   always #(HALF_PERIOD) clock = ~clock;

   // Shadow copy of the CPU registers, advanced once per accepted req word
   logic [7:0] cpu_a = 8'h00;
   logic [7:0] cpu_x = 8'h00;
   logic [7:0] cpu_y = 8'h00;
   logic [7:0] cpu_s = c6502_pkg::SP_RESET;
   logic [7:0] cpu_p = c6502_pkg::STATUS_RESET;

   retire_type retired_q [$];   // results still owed by the block, oldest first
   retire_type head;
   bit      failed    = 1'b0;
   bit      calm      = 1'b0;
   bit      hold_done = 1'b0;
   int      rsp_words = 0;

   // The first rows follow reset and can be worked out by hand: reset values,
   // pulled and pushed status, carry out of 0xFF, undecoded opcodes.
   stim_row_type opening_rows [0:26] = '{
      {OP_JAM,     8'h00, 8'h00, 1'b1,
       8'h00, 8'h00, 8'h00, c6502_pkg::SP_RESET, c6502_pkg::STATUS_RESET,
       8'h00, 1'b0, 1'b0, 1'b1},
      {OP_LDA_IMM, 8'hFF, 8'h00, 1'b1,
       8'hFF, 8'h00, 8'h00, 8'hFD, 8'hA4, 8'h00, 1'b0, 1'b0, 1'b0},
      {OP_PLP,     8'hFF, 8'h00, 1'b1,
       8'hFF, 8'h00, 8'h00, 8'hFE, 8'hEF, 8'h00, 1'b0, 1'b0, 1'b0},
      {OP_PHP,     8'h00, 8'h00, 1'b1,
       8'hFF, 8'h00, 8'h00, 8'hFD, 8'hEF, 8'hFF, 1'b1, 1'b0, 1'b0},
      {OP_BEQ,     8'h00, 8'h00, 1'b1,
       8'hFF, 8'h00, 8'h00, 8'hFD, 8'hEF, 8'h00, 1'b0, 1'b1, 1'b0},
      {OP_PLP,     8'h00, 8'h00, 1'b1,
       8'hFF, 8'h00, 8'h00, 8'hFE, 8'h20, 8'h00, 1'b0, 1'b0, 1'b0},
      {OP_ADC_IMM, 8'h01, 8'h00, 1'b1,
       8'h00, 8'h00, 8'h00, 8'hFE, 8'h23, 8'h00, 1'b0, 1'b0, 1'b0},
      {OP_BPL,     8'h00, 8'h00, 1'b1,
       8'h00, 8'h00, 8'h00, 8'hFE, 8'h23, 8'h00, 1'b0, 1'b1, 1'b0},
      {OP_XAA,     8'hFF, 8'hFF, 1'b1,
       8'h00, 8'h00, 8'h00, 8'hFE, 8'h23, 8'h00, 1'b0, 1'b0, 1'b1},
      // from here on the shadow registers decide
      {OP_SBC_IMM, 8'h80, 8'h00, 1'b0, NO_WANT},  // signed overflow into 0x80
      {OP_ARR,     8'hFF, 8'h00, 1'b0, NO_WANT},
      {OP_AXS,     8'h01, 8'h00, 1'b0, NO_WANT},
      {OP_SXA,     8'h7F, 8'hFF, 1'b0, NO_WANT},  // address high byte wraps to 0x00
      {OP_PHA,     8'h00, 8'h00, 1'b0, NO_WANT},
      {OP_PLA,     8'h80, 8'h00, 1'b0, NO_WANT},
      {OP_LDX_IMM, 8'h00, 8'h00, 1'b0, NO_WANT},
      {OP_TXS,     8'h00, 8'h00, 1'b0, NO_WANT},  // S = 0x00
      {OP_PHP,     8'h00, 8'h00, 1'b0, NO_WANT},  // S wraps down to 0xFF
      {OP_PLA,     8'h7F, 8'h00, 1'b0, NO_WANT},  // and back up to 0x00
      {OP_TSX,     8'h00, 8'h00, 1'b0, NO_WANT},
      {OP_ATX,     8'h00, 8'h00, 1'b0, NO_WANT},
      {OP_RRA_ABX, 8'hFF, 8'h00, 1'b0, NO_WANT},
      {OP_ISB_IZX, 8'hFF, 8'h00, 1'b0, NO_WANT},
      {OP_DCP_IZX, 8'h00, 8'h00, 1'b0, NO_WANT},
      {OP_BIT_ZP,  8'hC0, 8'h00, 1'b0, NO_WANT},
      {OP_SED,     8'h00, 8'h00, 1'b0, NO_WANT},
      {OP_ADC_IMM, 8'h99, 8'h00, 1'b0, NO_WANT}   // D set, sum stays binary
   };

   // ------------------------------------------------------------------
   // Instruction predictor
   // ------------------------------------------------------------------

   function automatic c6502_pkg::op_kind_type decode_op(input logic [7:0] op);
      case (op) inside
         8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: return c6502_pkg::K_ORA;
         8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: return c6502_pkg::K_AND;
         8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: return c6502_pkg::K_EOR;
         8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: return c6502_pkg::K_ADC;
         8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD, 8'hEB:
            return c6502_pkg::K_SBC;
         8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: return c6502_pkg::K_CMP;
         8'hE0, 8'hE4, 8'hEC: return c6502_pkg::K_CPX;
         8'hC0, 8'hC4, 8'hCC: return c6502_pkg::K_CPY;
         8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: return c6502_pkg::K_LDA;
         8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: return c6502_pkg::K_LDX;
         8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: return c6502_pkg::K_LDY;
         8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D: return c6502_pkg::K_STA;
         8'h86, 8'h8E, 8'h96: return c6502_pkg::K_STX;
         8'h84, 8'h8C, 8'h94: return c6502_pkg::K_STY;
         8'h0A: return c6502_pkg::K_ASL_A;
         8'h2A: return c6502_pkg::K_ROL_A;
         8'h4A: return c6502_pkg::K_LSR_A;
         8'h6A: return c6502_pkg::K_ROR_A;
         8'h06, 8'h0E, 8'h16, 8'h1E: return c6502_pkg::K_ASL_M;
         8'h26, 8'h2E, 8'h36, 8'h3E: return c6502_pkg::K_ROL_M;
         8'h46, 8'h4E, 8'h56, 8'h5E: return c6502_pkg::K_LSR_M;
         8'h66, 8'h6E, 8'h76, 8'h7E: return c6502_pkg::K_ROR_M;
         8'hC6, 8'hCE, 8'hD6, 8'hDE: return c6502_pkg::K_DEC_M;
         8'hE6, 8'hEE, 8'hF6, 8'hFE: return c6502_pkg::K_INC_M;
         8'h24, 8'h2C: return c6502_pkg::K_BIT;
         8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0:
            return c6502_pkg::K_BRANCH;
         8'h18: return c6502_pkg::K_CLC;
         8'h38: return c6502_pkg::K_SEC;
         8'h58: return c6502_pkg::K_CLI;
         8'h78: return c6502_pkg::K_SEI;
         8'hB8: return c6502_pkg::K_CLV;
         8'hD8: return c6502_pkg::K_CLD;
         8'hF8: return c6502_pkg::K_SED;
         8'hAA: return c6502_pkg::K_TAX;
         8'hA8: return c6502_pkg::K_TAY;
         8'hBA: return c6502_pkg::K_TSX;
         8'h8A: return c6502_pkg::K_TXA;
         8'h98: return c6502_pkg::K_TYA;
         8'h9A: return c6502_pkg::K_TXS;
         8'hE8: return c6502_pkg::K_INX;
         8'hC8: return c6502_pkg::K_INY;
         8'hCA: return c6502_pkg::K_DEX;
         8'h88: return c6502_pkg::K_DEY;
         8'h48: return c6502_pkg::K_PHA;
         8'h08: return c6502_pkg::K_PHP;
         8'h68: return c6502_pkg::K_PLA;
         8'h28: return c6502_pkg::K_PLP;
         // control flow and the documented and undocumented NOPs
         8'h00, 8'h20, 8'h40, 8'h60, 8'h4C, 8'h6C, 8'hEA, 8'h04, 8'h44, 8'h64,
         8'h0C, 8'h14, 8'h34, 8'h54, 8'h74, 8'hD4, 8'hF4, 8'h1A, 8'h3A, 8'h5A,
         8'h7A, 8'hDA, 8'hFA, 8'h80, 8'h82, 8'h89, 8'hC2, 8'hE2, 8'h1C, 8'h3C,
         8'h5C, 8'h7C, 8'hDC, 8'hFC: return c6502_pkg::K_NOP;
         8'hA3, 8'hA7, 8'hAF, 8'hB3, 8'hB7, 8'hBF, 8'hAB: return c6502_pkg::K_LAX;
         8'h83, 8'h87, 8'h8F, 8'h97: return c6502_pkg::K_SAX;
         8'hC3, 8'hC7, 8'hCF, 8'hD3, 8'hD7, 8'hDB, 8'hDF: return c6502_pkg::K_DCP;
         8'hE3, 8'hE7, 8'hEF, 8'hF3, 8'hF7, 8'hFB, 8'hFF: return c6502_pkg::K_ISB;
         8'h03, 8'h07, 8'h0F, 8'h13, 8'h17, 8'h1B, 8'h1F: return c6502_pkg::K_SLO;
         8'h23, 8'h27, 8'h2F, 8'h33, 8'h37, 8'h3B, 8'h3F: return c6502_pkg::K_RLA;
         8'h43, 8'h47, 8'h4F, 8'h53, 8'h57, 8'h5B, 8'h5F: return c6502_pkg::K_SRE;
         8'h63, 8'h67, 8'h6F, 8'h73, 8'h77, 8'h7B, 8'h7F: return c6502_pkg::K_RRA;
         8'h0B, 8'h2B: return c6502_pkg::K_ANC;
         8'h4B: return c6502_pkg::K_ALR;
         8'h6B: return c6502_pkg::K_ARR;
         8'hCB: return c6502_pkg::K_AXS;
         8'h9C: return c6502_pkg::K_SYA;
         8'h9E: return c6502_pkg::K_SXA;
         default: return c6502_pkg::K_INVALID;
      endcase
   endfunction

   function automatic logic [7:0] flag_nz(input logic [7:0] v);
      cpu_p[c6502_pkg::FLAG_Z] = (v == 8'h00);
      cpu_p[c6502_pkg::FLAG_N] = v[7];
      return v;
   endfunction

   // Binary add only; the D flag never changes the sum
   function automatic void add_with_carry(input logic [7:0] v);
      logic [8:0] sum;
      sum = {1'b0, cpu_a} + {1'b0, v} + {8'd0, cpu_p[c6502_pkg::FLAG_C]};
      cpu_p[c6502_pkg::FLAG_C] = sum[8];
      cpu_p[c6502_pkg::FLAG_V] = ~(cpu_a[7] ^ v[7]) & (cpu_a[7] ^ sum[7]);
      cpu_a = flag_nz(sum[7:0]);
   endfunction

   function automatic void compare_with(input logic [7:0] r, input logic [7:0] v);
      void'(flag_nz(r - v));
      cpu_p[c6502_pkg::FLAG_C] = (r >= v);
   endfunction

   function automatic logic [7:0] pred_asl(input logic [7:0] v);
      cpu_p[c6502_pkg::FLAG_C] = v[7];
      return flag_nz({v[6:0], 1'b0});
   endfunction

   function automatic logic [7:0] pred_lsr(input logic [7:0] v);
      cpu_p[c6502_pkg::FLAG_C] = v[0];
      return flag_nz({1'b0, v[7:1]});
   endfunction

   function automatic logic [7:0] pred_rol(input logic [7:0] v);
      logic [7:0] r;
      r = {v[6:0], cpu_p[c6502_pkg::FLAG_C]};
      cpu_p[c6502_pkg::FLAG_C] = v[7];
      return flag_nz(r);
   endfunction

   function automatic logic [7:0] pred_ror(input logic [7:0] v);
      logic [7:0] r;
      r = {cpu_p[c6502_pkg::FLAG_C], v[7:1]};
      cpu_p[c6502_pkg::FLAG_C] = v[0];
      return flag_nz(r);
   endfunction

   // Execute one instruction on the shadow registers and return what retires
   function automatic retire_type run_instruction(input logic [7:0] op, input logic [7:0] m,
                                                  input logic [7:0] hi);
      logic [7:0] wd;
      logic [7:0] t;
      logic       we;
      logic       br;
      logic       bad;
      logic       cond;
      wd  = 8'h00;
      we  = 1'b0;
      br  = 1'b0;
      bad = 1'b0;
      case (decode_op(op))
         c6502_pkg::K_ORA:   cpu_a = flag_nz(cpu_a | m);
         c6502_pkg::K_AND:   cpu_a = flag_nz(cpu_a & m);
         c6502_pkg::K_EOR:   cpu_a = flag_nz(cpu_a ^ m);
         c6502_pkg::K_ADC:   add_with_carry(m);
         c6502_pkg::K_SBC:   add_with_carry(~m);
         c6502_pkg::K_CMP:   compare_with(cpu_a, m);
         c6502_pkg::K_CPX:   compare_with(cpu_x, m);
         c6502_pkg::K_CPY:   compare_with(cpu_y, m);
         c6502_pkg::K_LDA:   cpu_a = flag_nz(m);
         c6502_pkg::K_LDX:   cpu_x = flag_nz(m);
         c6502_pkg::K_LDY:   cpu_y = flag_nz(m);
         c6502_pkg::K_STA:   begin wd = cpu_a; we = 1'b1; end
         c6502_pkg::K_STX:   begin wd = cpu_x; we = 1'b1; end
         c6502_pkg::K_STY:   begin wd = cpu_y; we = 1'b1; end
         c6502_pkg::K_ASL_A: cpu_a = pred_asl(cpu_a);
         c6502_pkg::K_ROL_A: cpu_a = pred_rol(cpu_a);
         c6502_pkg::K_LSR_A: cpu_a = pred_lsr(cpu_a);
         c6502_pkg::K_ROR_A: cpu_a = pred_ror(cpu_a);
         c6502_pkg::K_ASL_M: begin wd = pred_asl(m); we = 1'b1; end
         c6502_pkg::K_ROL_M: begin wd = pred_rol(m); we = 1'b1; end
         c6502_pkg::K_LSR_M: begin wd = pred_lsr(m); we = 1'b1; end
         c6502_pkg::K_ROR_M: begin wd = pred_ror(m); we = 1'b1; end
         c6502_pkg::K_DEC_M: begin wd = flag_nz(m - 8'd1); we = 1'b1; end
         c6502_pkg::K_INC_M: begin wd = flag_nz(m + 8'd1); we = 1'b1; end
         c6502_pkg::K_BIT: begin
            cpu_p[c6502_pkg::FLAG_Z] = ((cpu_a & m) == 8'h00);
            cpu_p[c6502_pkg::FLAG_V] = m[6];
            cpu_p[c6502_pkg::FLAG_N] = m[7];
         end
         c6502_pkg::K_BRANCH: begin
            // bit 5 of the opcode gives the flag value that takes the branch
            case (op)
               OP_BPL, OP_BMI: cond = cpu_p[c6502_pkg::FLAG_N];
               OP_BVC, OP_BVS: cond = cpu_p[c6502_pkg::FLAG_V];
               OP_BCC, OP_BCS: cond = cpu_p[c6502_pkg::FLAG_C];
               default:        cond = cpu_p[c6502_pkg::FLAG_Z];
            endcase
            br = (cond == op[5]);
         end
         c6502_pkg::K_CLC:   cpu_p[c6502_pkg::FLAG_C] = 1'b0;
         c6502_pkg::K_SEC:   cpu_p[c6502_pkg::FLAG_C] = 1'b1;
         c6502_pkg::K_CLI:   cpu_p[c6502_pkg::FLAG_I] = 1'b0;
         c6502_pkg::K_SEI:   cpu_p[c6502_pkg::FLAG_I] = 1'b1;
         c6502_pkg::K_CLV:   cpu_p[c6502_pkg::FLAG_V] = 1'b0;
         c6502_pkg::K_CLD:   cpu_p[c6502_pkg::FLAG_D] = 1'b0;
         c6502_pkg::K_SED:   cpu_p[c6502_pkg::FLAG_D] = 1'b1;
         c6502_pkg::K_TAX:   cpu_x = flag_nz(cpu_a);
         c6502_pkg::K_TAY:   cpu_y = flag_nz(cpu_a);
         c6502_pkg::K_TSX:   cpu_x = flag_nz(cpu_s);
         c6502_pkg::K_TXA:   cpu_a = flag_nz(cpu_x);
         c6502_pkg::K_TYA:   cpu_a = flag_nz(cpu_y);
         c6502_pkg::K_TXS:   cpu_s = cpu_x;
         c6502_pkg::K_INX:   cpu_x = flag_nz(cpu_x + 8'd1);
         c6502_pkg::K_INY:   cpu_y = flag_nz(cpu_y + 8'd1);
         c6502_pkg::K_DEX:   cpu_x = flag_nz(cpu_x - 8'd1);
         c6502_pkg::K_DEY:   cpu_y = flag_nz(cpu_y - 8'd1);
         c6502_pkg::K_PHA:   begin wd = cpu_a; we = 1'b1; cpu_s = cpu_s - 8'd1; end
         c6502_pkg::K_PHP: begin
            wd    = cpu_p | c6502_pkg::MASK_BR;
            we    = 1'b1;
            cpu_s = cpu_s - 8'd1;
         end
         c6502_pkg::K_PLA:   begin cpu_s = cpu_s + 8'd1; cpu_a = flag_nz(m); end
         c6502_pkg::K_PLP: begin
            cpu_s = cpu_s + 8'd1;
            cpu_p = (m & ~c6502_pkg::MASK_B) | c6502_pkg::MASK_R;
         end
         c6502_pkg::K_NOP:   ;
         c6502_pkg::K_LAX:   begin cpu_x = flag_nz(m); cpu_a = m; end
         c6502_pkg::K_SAX:   begin wd = cpu_a & cpu_x; we = 1'b1; end
         c6502_pkg::K_DCP:   begin wd = m - 8'd1; we = 1'b1; compare_with(cpu_a, wd); end
         c6502_pkg::K_ISB:   begin wd = m + 8'd1; we = 1'b1; add_with_carry(~wd); end
         c6502_pkg::K_SLO:   begin wd = pred_asl(m); we = 1'b1; cpu_a = flag_nz(cpu_a | wd); end
         c6502_pkg::K_RLA:   begin wd = pred_rol(m); we = 1'b1; cpu_a = flag_nz(cpu_a & wd); end
         c6502_pkg::K_SRE:   begin wd = pred_lsr(m); we = 1'b1; cpu_a = flag_nz(cpu_a ^ wd); end
         c6502_pkg::K_RRA:   begin wd = pred_ror(m); we = 1'b1; add_with_carry(wd); end
         c6502_pkg::K_ANC: begin
            cpu_a = flag_nz(cpu_a & m);
            cpu_p[c6502_pkg::FLAG_C] = cpu_a[7];
         end
         c6502_pkg::K_ALR: begin
            t = cpu_a & m;
            cpu_p[c6502_pkg::FLAG_C] = t[0];
            cpu_a = flag_nz({1'b0, t[7:1]});
         end
         c6502_pkg::K_ARR: begin
            // rotate in the old carry, then C and V come from bits 6 and 5
            t = (cpu_a & m) >> 1;
            t[7] = cpu_p[c6502_pkg::FLAG_C];
            cpu_a = flag_nz(t);
            cpu_p[c6502_pkg::FLAG_C] = t[6];
            cpu_p[c6502_pkg::FLAG_V] = t[6] ^ t[5];
         end
         c6502_pkg::K_AXS: begin
            t = cpu_a & cpu_x;
            cpu_p[c6502_pkg::FLAG_C] = (t >= m);
            cpu_x = flag_nz(t - m);
         end
         c6502_pkg::K_SYA:   begin wd = cpu_y & (hi + 8'd1); we = 1'b1; end
         c6502_pkg::K_SXA:   begin wd = cpu_x & (hi + 8'd1); we = 1'b1; end
         default: bad = 1'b1;
      endcase
      return {cpu_a, cpu_x, cpu_y, cpu_s, cpu_p, (we ? wd : 8'h00), we, br, bad};
   endfunction

   // ------------------------------------------------------------------
   // req side
   // ------------------------------------------------------------------

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one word, hold it until accepted, then log what it must retire as
   task automatic issue_word(input logic [7:0] op, input logic [7:0] operand,
                             input logic [7:0] hi, input logic typed = 1'b0,
                             input retire_type want = NO_WANT);
      retire_type got;
      req_valid     <= 1'b1;
      req_op        <= op;
      req_operand   <= operand;
      req_addr_high <= hi;
      do @(posedge clock); while (!req_ready);
      got = run_instruction(op, operand, hi);
      retired_q.push_back(typed ? want : got);
   endtask

   // Drop valid for a random burst now and then
   task automatic maybe_idle();
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Park S near a wrap point or at a random value, then push and pull across it
   task automatic stack_burst();
      logic [7:0] stack_ops [4];
      logic [7:0] base;
      stack_ops = '{OP_PHA, OP_PHP, OP_PLA, OP_PLP};
      case ($urandom_range(0, 4))
         0:       base = 8'h00;
         1:       base = 8'h01;
         2:       base = 8'hFF;
         3:       base = 8'hFE;
         default: base = rand_byte();
      endcase
      issue_word(OP_LDX_IMM, base, rand_byte());
      issue_word(OP_TXS, rand_byte(), rand_byte());
      repeat ($urandom_range(1, 4))
         issue_word(stack_ops[$urandom_range(0, 3)], rand_byte(), rand_byte());
   endtask

   initial begin : stimulus
      logic [7:0] order [256];
      logic [7:0] swap;
      int         j;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed opening
      foreach (opening_rows[i]) begin
         issue_word(opening_rows[i].op, opening_rows[i].operand, opening_rows[i].hi,
                    opening_rows[i].typed, opening_rows[i].want);
         maybe_idle();
      end

      // Hold the sender until the block has drained
      req_valid <= 1'b0;
      while (retired_q.size() != 0) @(posedge clock);

      // Every opcode once, in shuffled order; the long rsp hold lands in here
      for (int k = 0; k < 256; k++) order[k] = 8'(k);
      for (int k = 255; k > 0; k--) begin
         j        = $urandom_range(0, k);
         swap     = order[k];
         order[k] = order[j];
         order[j] = swap;
      end
      for (int k = 0; k < 256; k++) begin
         issue_word(order[k], rand_byte(), rand_byte());
         maybe_idle();
      end

      // Random instructions with stack work mixed in; the tail runs at full rate
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == CALM_FROM) calm = 1'b1;
         if ($urandom_range(0, 7) == 0)
            stack_burst();
         else
            issue_word(8'($urandom_range(0, 255)), rand_byte(), rand_byte());
         maybe_idle();
      end

      req_valid <= 1'b0;
      while (retired_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (failed)
         $display("cpu6502_alu_register_step: mismatch");
      else
         $display("cpu6502_alu_register_step: match");
      $finish;
   end

   // ------------------------------------------------------------------
   // rsp side
   // ------------------------------------------------------------------

   // Stall in short random bursts, once for a long stretch, never in the tail
   initial begin : rsp_pacing
      while (reset) @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!hold_done && rsp_words >= HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected %02h, got %02h", $time, name, want_v, got_v);
         failed = 1'b1;
      end
   endtask

   // Match each retired word against the oldest outstanding one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_words++;
         if (retired_q.size() == 0) begin
            $display("%0t: rsp word with nothing outstanding, expected none, got acc %02h",
                     $time, rsp_acc);
            failed = 1'b1;
         end else begin
            head = retired_q.pop_front();
            check_field("acc",          head.acc,       rsp_acc);
            check_field("index_x",      head.x,         rsp_index_x);
            check_field("index_y",      head.y,         rsp_index_y);
            check_field("stack_ptr",    head.sp,        rsp_stack_ptr);
            check_field("status",       head.p,         rsp_status);
            check_field("write_data",   head.wd,        rsp_write_data);
            check_field("write_enable", {7'd0, head.we},  {7'd0, rsp_write_enable});
            check_field("branch_taken", {7'd0, head.br},  {7'd0, rsp_branch_taken});
            check_field("invalid_op",   {7'd0, head.bad}, {7'd0, rsp_invalid_op});
         end
      end
   end

   initial begin : watchdog
      #(WATCHDOG_NS);
      $display("cpu6502_alu_register_step: mismatch");
      $finish;
   end

endmodule
